// ===== sv/tcte_pkg.sv =====
// Shared types and constants for the tick count to epoch seconds unit.
`default_nettype none

package tcte_pkg;

    localparam int unsigned TickW    = 64;
    localparam int unsigned DivW     = 32;
    localparam int unsigned SecW     = 32;
    localparam int unsigned LowW     = 31;
    localparam int unsigned NumDivSt = 31;

    localparam logic [TickW-1:0] EpochOffsetRst    = 64'h019D_B1DE_D53E_8000;
    localparam logic [DivW-1:0]  TicksPerSecondRst = 32'd10000000;

    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CfgEpochOffset    = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgTicksPerSecond = 2'd1;

    typedef struct packed {
        logic             err;
        logic             zero;
        logic [DivW-1:0]  rem;
        logic [LowW-1:0]  low;
        logic [LowW-1:0]  quo;
    } div_stage_t;

endpackage

`default_nettype wire

// ===== sv/tick_count_to_epoch_seconds_unit.sv =====
// Top level: converts 100 ns tick counts to seconds since a target epoch.
//
// Input stream s_*: one 64-bit tick count per transaction.
// Output stream m_*: one result per input, seconds in m_tdata and the error
// flag in m_tuser; seconds reads -1 whenever the error flag is set.
// Configuration channel cfg_*: index 0 writes the 64-bit epoch offset,
// index 1 the 32-bit ticks-per-second divisor; other indexes are ignored.
// cfg_ready is always high; write only while no transaction is in flight.
// Datapath: one subtract stage, one stage that checks for a quotient of
// 2^31 or more and loads the remainder, then 31 restoring divide stages,
// one quotient bit each, all registered. A new transaction can enter every
// cycle while the pipeline is not held by the output stall described below.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the reset epoch offset
// (0x019DB1DED53E8000) and divisor (10000000).
`default_nettype none

module tick_count_to_epoch_seconds_unit
    import tcte_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output      logic               s_tready,
    input  wire logic [TickW-1:0]   s_tdata,   // [63:0] tick_count
    output      logic               m_tvalid,
    input  wire logic               m_tready,
    output      logic [SecW-1:0]    m_tdata,   // [31:0] seconds
    output      logic               m_tuser,   // [0] error
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [TickW-1:0]   cfg_data
);

    logic [TickW-1:0] offset_reg;
    logic [DivW-1:0]  divisor_reg;

    logic             adv;

    logic             a_valid_reg;
    logic             a_err_reg;
    logic [TickW-1:0] a_diff_reg;
    logic [TickW:0]   a_sub;

    logic             p_valid_reg [0:NumDivSt];
    div_stage_t       p_reg       [0:NumDivSt];
    div_stage_t       p_next      [0:NumDivSt];

    logic [DivW:0]    b_top;
    logic             b_zero;
    logic             b_ovf;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= EpochOffsetRst;
            divisor_reg <= TicksPerSecondRst;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CfgEpochOffset:    offset_reg  <= cfg_data;
                CfgTicksPerSecond: divisor_reg <= cfg_data[DivW-1:0];
                default:           ;
            endcase
        end
    end

    assign adv      = !p_valid_reg[NumDivSt] || m_tready;
    assign s_tready = adv;

    // stage A: subtract epoch offset
    assign a_sub = {1'b0, s_tdata} - {1'b0, offset_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_err_reg  <= a_sub[TickW];
            a_diff_reg <= a_sub[TickW-1:0];
        end
    end

    // stage B: overflow check, remainder holds the top bits
    assign b_top  = a_diff_reg[TickW-1:LowW];
    assign b_zero = (divisor_reg == '0);
    assign b_ovf  = (b_top >= {1'b0, divisor_reg});

    always_comb
    begin
        p_next[0].err  = a_err_reg || (!b_zero && b_ovf);
        p_next[0].zero = b_zero;
        p_next[0].rem  = b_top[DivW-1:0];
        p_next[0].low  = a_diff_reg[LowW-1:0];
        p_next[0].quo  = '0;
    end

    // restoring divide stages, one quotient bit each
    for (genvar k = 1; k <= NumDivSt; k++)
    begin : g_div
        logic [DivW:0] trial;
        logic [DivW:0] diff;
        logic          ge;

        assign trial = {p_reg[k-1].rem, p_reg[k-1].low[LowW-1]};
        assign diff  = trial - {1'b0, divisor_reg};
        assign ge    = (trial >= {1'b0, divisor_reg});

        always_comb
        begin
            p_next[k].err  = p_reg[k-1].err;
            p_next[k].zero = p_reg[k-1].zero;
            p_next[k].rem  = ge ? diff[DivW-1:0] : trial[DivW-1:0];
            p_next[k].low  = {p_reg[k-1].low[LowW-2:0], 1'b0};
            p_next[k].quo  = {p_reg[k-1].quo[LowW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NumDivSt; i++)
            begin
                p_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            p_valid_reg[0] <= a_valid_reg;
            for (int i = 1; i <= NumDivSt; i++)
            begin
                p_valid_reg[i] <= p_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= NumDivSt; i++)
            begin
                p_reg[i] <= p_next[i];
            end
        end
    end

    // output
    assign m_tvalid = p_valid_reg[NumDivSt];
    assign m_tuser  = p_reg[NumDivSt].err;
    assign m_tdata  = p_reg[NumDivSt].err  ? '1 :
                      p_reg[NumDivSt].zero ? '0 :
                      {1'b0, p_reg[NumDivSt].quo};

`ifndef ASSERT_OFF
    a_err_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '1)
        else $error("error result without all-ones seconds");

    a_ok_positive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> !m_tdata[SecW-1])
        else $error("valid result with sign bit set");

    a_before_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && adv && a_err_reg |=> p_valid_reg[0] && p_reg[0].err)
        else $error("before-epoch flag lost entering divider");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg[0] && !p_reg[0].err && !p_reg[0].zero
        |-> p_reg[0].rem < divisor_reg)
        else $error("remainder not below divisor after overflow check");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(p_reg[NumDivSt]))
        else $error("pending result changed during stall");
`endif

endmodule

`default_nettype wire

// ===== verif/tick_count_to_epoch_seconds_unit_tb.sv =====
// Testbench for tick_count_to_epoch_seconds_unit: directed and random tick counts, scoreboard check.
`timescale 1ns / 1ps

module tick_count_to_epoch_seconds_unit_tb;
    import tcte_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgUnusedA = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgUnusedB = 2'd3;
    localparam logic [63:0] QuotientLimit = 64'd2147483648;
    localparam logic [63:0] TickMax = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int unsigned DrainCycles = 40;
    localparam int unsigned CycleLimit = 200000;

    typedef struct packed {
        logic [SecW-1:0] seconds;
        logic            error;
    } seconds_result_t;

    class epoch_scoreboard;
        logic [TickW-1:0] epoch_offset;
        logic [DivW-1:0]  ticks_per_second;
        seconds_result_t  pending_seconds[$];
        int unsigned      fail_count;

        function new();
            epoch_offset = EpochOffsetRst;
            ticks_per_second = TicksPerSecondRst;
            fail_count = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] data);
            case (idx)
                CfgEpochOffset:    epoch_offset = data;
                CfgTicksPerSecond: ticks_per_second = data[DivW-1:0];
                default: ;
            endcase
        endfunction

        // Predict seconds/error for one accepted tick count.
        function void note_tick(logic [TickW-1:0] ticks);
            logic [63:0]     span;
            logic [63:0]     quotient;
            seconds_result_t res;
            res.error = 1'b0;
            quotient = '0;
            if (ticks < epoch_offset) begin
                res.error = 1'b1;
            end
            else begin
                span = ticks - epoch_offset;
                if (ticks_per_second != '0)
                    quotient = span / {32'd0, ticks_per_second};
                res.error = (quotient >= QuotientLimit);
            end
            res.seconds = res.error ? '1 : quotient[SecW-1:0];
            pending_seconds.push_back(res);
        endfunction

        function void check_result(logic [SecW-1:0] seconds, logic error);
            seconds_result_t exp_res;
            if (pending_seconds.size() == 0) begin
                $display("%0t: unexpected result seconds=%h error=%b", $time, seconds, error);
                fail_count++;
                return;
            end
            exp_res = pending_seconds.pop_front();
            if (seconds !== exp_res.seconds) begin
                $display("%0t: seconds mismatch expected=%h actual=%h",
                         $time, exp_res.seconds, seconds);
                fail_count++;
            end
            if (error !== exp_res.error) begin
                $display("%0t: error mismatch expected=%b actual=%b",
                         $time, exp_res.error, error);
                fail_count++;
            end
        endfunction

        function int unsigned pending();
            return pending_seconds.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TickW-1:0]   s_tdata = '0;   // [63:0] tick_count
    logic               m_tvalid;
    logic               m_tready = 1'b1;
    logic [SecW-1:0]    m_tdata;        // [31:0] seconds
    logic               m_tuser;        // [0] error
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [TickW-1:0]   cfg_data = '0;

    int unsigned     sender_idle_pct = 0;
    int unsigned     receiver_stall_pct = 0;
    int unsigned     cycle_count = 0;
    epoch_scoreboard board;

    tick_count_to_epoch_seconds_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check each accepted transaction, then pick next tready.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic set_idle(input int unsigned sender_pct, input int unsigned receiver_pct);
        sender_idle_pct = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    task automatic send_tick(input logic [TickW-1:0] ticks);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ticks;
        do @(posedge clk); while (!s_tready);
        board.note_tick(ticks);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    // Unused index gets junk data in between; it must not disturb anything.
    task automatic configure(input logic [TickW-1:0] offset, input logic [DivW-1:0] tps);
        write_reg(CfgEpochOffset, offset);
        write_reg($urandom_range(1) ? CfgUnusedA : CfgUnusedB, {$urandom, $urandom});
        write_reg(CfgTicksPerSecond, {$urandom, tps});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Mostly well-formed counts around the current epoch, some before it, some noise.
    function automatic logic [TickW-1:0] random_tick();
        logic [63:0]      quotient;
        logic [63:0]      rest;
        logic [TickW-1:0] off;
        logic [DivW-1:0]  tps;
        int unsigned      kind;
        off = board.epoch_offset;
        tps = board.ticks_per_second;
        kind = $urandom_range(9);
        if (kind < 2)
            return {$urandom, $urandom};
        if (kind == 2)
            return off - $urandom_range(1, 5000);
        if (kind == 3)
            quotient = 64'h7FFF_FFFE + $urandom_range(0, 3);
        else
            quotient = {32'd0, $urandom} >> $urandom_range(1, 31);
        rest = (tps == '0) ? {32'd0, $urandom} : {32'd0, $urandom % tps};
        return off + quotient * {32'd0, tps} + rest;
    endfunction

    task automatic random_ticks(input int unsigned count);
        repeat (count) send_tick(random_tick());
        s_tvalid <= 1'b0;
        wait_idle();
    endtask

    initial
    begin
        logic [TickW-1:0] offset;
        logic [TickW-1:0] rst_tps;
        board = new();
        rst_tps = {32'd0, TicksPerSecondRst};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        set_idle(0, 0);
        send_tick('0);
        send_tick(EpochOffsetRst - 1);
        send_tick(EpochOffsetRst);
        send_tick(EpochOffsetRst + rst_tps - 1);
        send_tick(EpochOffsetRst + rst_tps);
        send_tick(EpochOffsetRst + 64'd2147483647 * rst_tps + rst_tps - 1);
        send_tick(EpochOffsetRst + QuotientLimit * rst_tps);
        send_tick(TickMax);
        random_ticks(100);

        // divisor of one: quotient is the tick count itself
        configure('0, 32'd1);
        set_idle(56, 0);
        send_tick('0);
        send_tick(64'd2147483647);
        send_tick(QuotientLimit);
        send_tick(TickMax);
        random_ticks(100);

        configure(TickMax, '1);
        set_idle(0, 56);
        send_tick(TickMax);
        send_tick(TickMax - 1);
        send_tick('0);
        random_ticks(100);

        // zero divisor
        offset = {$urandom, $urandom} | 64'd1;
        configure(offset, '0);
        set_idle(29, 29);
        send_tick(offset - 1);
        send_tick(offset);
        send_tick(TickMax);
        random_ticks(100);

        configure('0, '1);
        set_idle(0, 0);
        send_tick(64'd2147483647 * 64'hFFFF_FFFF + 64'hFFFF_FFFE);
        send_tick(TickMax);
        send_tick(64'hFFFF_FFFE);
        random_ticks(100);

        configure({$urandom, $urandom}, $urandom);
        set_idle(56, 0);
        random_ticks(100);

        configure({$urandom, $urandom}, $urandom >> $urandom_range(8, 28));
        set_idle(0, 56);
        random_ticks(100);

        configure(EpochOffsetRst, TicksPerSecondRst);
        set_idle(29, 29);
        random_ticks(100);

        if (board.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
